/* rtl/core/eia_pkg.sv */
// Shared constants, codes and control types for the entity identifier allocator.
package eia_pkg;

    localparam int NUM_IDS  = 1024;
    localparam int SIG_BITS = 32;

    localparam int ID_W  = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
    localparam int CNT_W = $clog2(NUM_IDS + 1);

    // Widths of the block's ports, fixed by the interface.
    localparam int CMD_PORT_W    = 2;
    localparam int ID_PORT_W     = 10;
    localparam int SIG_PORT_W    = 32;
    localparam int STATUS_PORT_W = 2;
    localparam int COUNT_PORT_W  = 11;

    typedef enum logic [CMD_PORT_W-1:0] {
        CMD_CREATE  = 2'd0,
        CMD_DESTROY = 2'd1,
        CMD_SET_SIG = 2'd2,
        CMD_GET_SIG = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_PORT_W-1:0] {
        STAT_OK           = 2'd0,
        STAT_NONE_FREE    = 2'd1,
        STAT_OUT_OF_RANGE = 2'd2,
        STAT_LIST_FULL    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic clear_en;
        logic load;
        logic exec;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
    } dp_status_t;

endpackage

/* rtl/core/eia_ctrl.sv */
// Controller state machine: clearing pass after reset, then accept and execute items.
module eia_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  eia_pkg::dp_status_t   dp_stat,
    output eia_pkg::ctrl_cmd_t    ctrl,
    output logic                  busy
);

    eia_pkg::state_t state_reg;
    eia_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= eia_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        ctrl.clear_en = 1'b0;
        ctrl.load     = 1'b0;
        ctrl.exec     = 1'b0;
        busy          = 1'b1;
        unique case (state_reg)
            eia_pkg::ST_CLEAR:
            begin
                ctrl.clear_en = 1'b1;
                if (dp_stat.clear_last)
                begin
                    state_next = eia_pkg::ST_IDLE;
                end
            end
            eia_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctrl.load  = 1'b1;
                    state_next = eia_pkg::ST_EXEC;
                end
            end
            eia_pkg::ST_EXEC:
            begin
                ctrl.exec  = 1'b1;
                state_next = eia_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = eia_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/eia_datapath.sv */
// Datapath: free ring and signature memories, pointers, in-use count and result registers.
module eia_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  eia_pkg::ctrl_cmd_t                  ctrl,
    output eia_pkg::dp_status_t                 dp_stat,
    input  logic [eia_pkg::CMD_PORT_W-1:0]      cmd,
    input  logic [eia_pkg::ID_PORT_W-1:0]       entity_id,
    input  logic [eia_pkg::SIG_PORT_W-1:0]      signature_in,
    output logic                                done,
    output logic [eia_pkg::ID_PORT_W-1:0]       allocated_id,
    output logic [eia_pkg::SIG_PORT_W-1:0]      signature_out,
    output logic [eia_pkg::STATUS_PORT_W-1:0]   status,
    output logic [eia_pkg::COUNT_PORT_W-1:0]    active_count
);

    localparam int ID_W  = eia_pkg::ID_W;
    localparam int CNT_W = eia_pkg::CNT_W;
    localparam int SIG_W = eia_pkg::SIG_BITS;

    logic [ID_W-1:0]  ring_mem [eia_pkg::NUM_IDS];
    logic [SIG_W-1:0] sig_mem  [eia_pkg::NUM_IDS];

    logic [ID_W-1:0]  head_reg;
    logic [ID_W-1:0]  head_next;
    logic [ID_W-1:0]  tail_reg;
    logic [ID_W-1:0]  tail_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [ID_W-1:0]  clr_reg;

    eia_pkg::cmd_t    cmd_reg;
    logic [ID_W-1:0]  id_reg;
    logic             in_range_reg;
    logic [SIG_W-1:0] sig_reg;
    logic [ID_W-1:0]  ring_rd_reg;
    logic [SIG_W-1:0] sig_rd_reg;

    logic [ID_W-1:0]  id_idx;
    logic             ring_we;
    logic             sig_we;
    logic [SIG_W-1:0] sig_wdata;
    eia_pkg::status_t stat_val;
    logic [ID_W-1:0]  alloc_val;
    logic [SIG_W-1:0] sig_out_val;

    logic                                done_reg;
    logic [eia_pkg::ID_PORT_W-1:0]       allocated_id_reg;
    logic [eia_pkg::SIG_PORT_W-1:0]      signature_out_reg;
    logic [eia_pkg::STATUS_PORT_W-1:0]   status_reg;
    logic [eia_pkg::COUNT_PORT_W-1:0]    active_count_reg;

    assign id_idx             = ID_W'(entity_id);
    assign dp_stat.clear_last = (clr_reg == ID_W'(eia_pkg::NUM_IDS - 1));

    // Latch the item and read both memories at the address it needs.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg      <= eia_pkg::cmd_t'(cmd);
            id_reg       <= id_idx;
            in_range_reg <= (32'(entity_id) < eia_pkg::NUM_IDS);
            sig_reg      <= SIG_W'(signature_in);
            ring_rd_reg  <= ring_mem[head_reg];
            sig_rd_reg   <= sig_mem[id_idx];
        end
    end

    // The clearing pass after reset refills the ring in order and zeroes the table.
    always_ff @(posedge clk)
    begin
        if (ctrl.clear_en)
        begin
            ring_mem[clr_reg] <= clr_reg;
            sig_mem[clr_reg]  <= '0;
        end
        else
        begin
            if (ring_we)
            begin
                ring_mem[tail_reg] <= id_reg;
            end
            if (sig_we)
            begin
                sig_mem[id_reg] <= sig_wdata;
            end
        end
    end

    always_comb
    begin
        stat_val    = eia_pkg::STAT_OK;
        alloc_val   = '0;
        sig_out_val = '0;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        ring_we     = 1'b0;
        sig_we      = 1'b0;
        sig_wdata   = '0;
        if (cmd_reg == eia_pkg::CMD_CREATE)
        begin
            if (count_reg >= CNT_W'(eia_pkg::NUM_IDS))
            begin
                stat_val = eia_pkg::STAT_NONE_FREE;
            end
            else
            begin
                alloc_val  = ring_rd_reg;
                head_next  = (head_reg == ID_W'(eia_pkg::NUM_IDS - 1)) ? '0 : head_reg + 1'b1;
                count_next = count_reg + 1'b1;
            end
        end
        else if (!in_range_reg)
        begin
            stat_val = eia_pkg::STAT_OUT_OF_RANGE;
        end
        else
        begin
            case (cmd_reg)
                eia_pkg::CMD_DESTROY:
                begin
                    if (count_reg == '0)
                    begin
                        stat_val = eia_pkg::STAT_LIST_FULL;
                    end
                    else
                    begin
                        ring_we    = ctrl.exec;
                        sig_we     = ctrl.exec;
                        tail_next  = (tail_reg == ID_W'(eia_pkg::NUM_IDS - 1)) ?
                                     '0 : tail_reg + 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
                eia_pkg::CMD_SET_SIG:
                begin
                    sig_we    = ctrl.exec;
                    sig_wdata = sig_reg;
                end
                default:
                begin
                    sig_out_val = sig_rd_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.exec;
            if (ctrl.clear_en)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (ctrl.exec)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.exec)
        begin
            allocated_id_reg  <= eia_pkg::ID_PORT_W'(alloc_val);
            signature_out_reg <= eia_pkg::SIG_PORT_W'(sig_out_val);
            status_reg        <= stat_val;
            active_count_reg  <= eia_pkg::COUNT_PORT_W'(count_next);
        end
    end

    assign done          = done_reg;
    assign allocated_id  = allocated_id_reg;
    assign signature_out = signature_out_reg;
    assign status        = status_reg;
    assign active_count  = active_count_reg;

endmodule

/* rtl/core/entity_id_allocator.sv */
// Top level of the entity identifier allocator: controller and datapath.
//
//  Channel   Handshake               Payload
//  command   start in, busy out      cmd, entity_id, signature_in
//  result    done out (one cycle)    allocated_id, signature_out, status, active_count
//
// An item runs in two steps: the accepting cycle reads the free ring and the
// signature memory, the next cycle executes and registers the result.
// The result shows with done in the cycle after that, when a new item may be accepted.
// After reset a clearing pass over all NUM_IDS (1024) entries refills the ring and
// zeroes the signature table; busy stays high throughout it.
// The receiver cannot stall, so nothing else holds the block up.
module entity_id_allocator
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [eia_pkg::CMD_PORT_W-1:0]      cmd,
    input  logic [eia_pkg::ID_PORT_W-1:0]       entity_id,
    input  logic [eia_pkg::SIG_PORT_W-1:0]      signature_in,
    output logic                                done,
    output logic [eia_pkg::ID_PORT_W-1:0]       allocated_id,
    output logic [eia_pkg::SIG_PORT_W-1:0]      signature_out,
    output logic [eia_pkg::STATUS_PORT_W-1:0]   status,
    output logic [eia_pkg::COUNT_PORT_W-1:0]    active_count
);

    eia_pkg::ctrl_cmd_t  ctrl;
    eia_pkg::dp_status_t dp_stat;

    eia_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .dp_stat (dp_stat),
        .ctrl    (ctrl),
        .busy    (busy)
    );

    eia_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .dp_stat       (dp_stat),
        .cmd           (cmd),
        .entity_id     (entity_id),
        .signature_in  (signature_in),
        .done          (done),
        .allocated_id  (allocated_id),
        .signature_out (signature_out),
        .status        (status),
        .active_count  (active_count)
    );

endmodule
